/* rtl/tcn_pkg.sv */
// Shared types, codes and saturating helpers for the threshold charge neuron.
package tcn_pkg;

  localparam int CHG_W     = 32;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int AMT_W     = CHG_W - 1;
  localparam int PROD_W    = AMT_W + FRAC_W;
  localparam int FUNC_W    = 3;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [CHG_W-1:0] chg_t;
  typedef logic [AMT_W-1:0]        amt_t;
  typedef logic [FRAC_W-1:0]       frac_t;
  typedef logic [FUNC_W-1:0]       func_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

  localparam func_t FUNC_ADD     = 3'd0;
  localparam func_t FUNC_ASSIM   = 3'd1;
  localparam func_t FUNC_INJECT  = 3'd2;
  localparam func_t FUNC_DECAY   = 3'd3;
  localparam func_t FUNC_TRIGGER = 3'd4;
  localparam func_t FUNC_CLEAR   = 3'd5;

  localparam cfg_idx_t CFG_FIRE_THRESHOLD  = 3'd0;
  localparam cfg_idx_t CFG_FIRE_FIXED_COST = 3'd1;
  localparam cfg_idx_t CFG_FIRE_FRACTION   = 3'd2;
  localparam cfg_idx_t CFG_LEAK_FIXED      = 3'd3;
  localparam cfg_idx_t CFG_LEAK_FRACTION   = 3'd4;

  localparam frac_t FRAC_ONE = frac_t'(1 << FRAC_BITS);
  localparam chg_t  CHG_MAX  = {1'b0, {(CHG_W-1){1'b1}}};
  localparam chg_t  CHG_MIN  = {1'b1, {(CHG_W-1){1'b0}}};

  typedef struct packed {
    chg_t  thr;
    amt_t  fire_cost;
    frac_t fire_frac;
    amt_t  leak_fixed;
    frac_t leak_frac;
  } cfg_t;

  typedef struct packed {
    func_t func;
    chg_t  charge_in;
    chg_t  cur;
    chg_t  pend;
  } core_in_t;

  typedef struct packed {
    chg_t signal;
    logic above;
    chg_t cur;
    chg_t pend;
  } core_res_t;

  function automatic chg_t sat_add(chg_t a, chg_t b);
    logic [CHG_W:0] s;
    s = {a[CHG_W-1], a} + {b[CHG_W-1], b};
    if (s[CHG_W] != s[CHG_W-1]) begin
      sat_add = s[CHG_W] ? CHG_MIN : CHG_MAX;
    end else begin
      sat_add = s[CHG_W-1:0];
    end
  endfunction

  function automatic frac_t frac_sat(frac_t f);
    frac_sat = (f > FRAC_ONE) ? FRAC_ONE : f;
  endfunction

endpackage

/* rtl/tcn_ifs.sv */
// Valid/ready channel interfaces for event input and result output.
interface tcn_in_if import tcn_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  chg_t  charge_in;

  modport source (output valid, output func, output charge_in, input ready);
  modport sink   (input valid, input func, input charge_in, output ready);
endinterface

interface tcn_out_if import tcn_pkg::*; ();
  logic valid;
  logic ready;
  chg_t signal_out;
  logic above_threshold;
  chg_t current_level;
  chg_t pending_level;

  modport source (output valid, output signal_out, output above_threshold,
                  output current_level, output pending_level, input ready);
  modport sink   (input valid, input signal_out, input above_threshold,
                  input current_level, input pending_level, output ready);
endinterface

/* rtl/threshold_charge_neuron.sv */
// Threshold charge neuron top level: input register, event logic, result register.
//
//   channel | dir | transfer / write             | payload
//   in_ch   | in  | valid & ready                | func, charge_in
//   out_ch  | out | valid & ready                | signal_out, above_threshold,
//           |     |                              | current_level, pending_level
//   cfg_*   | in  | cfg_we high                  | cfg_index, cfg_wdata
//
// One event per cycle sustained while out_ch is ready; an event passes the input register, then the result register.
// The charge registers update as an event moves from the input register to
// the result register, so each event sees the previous one's state.
// rst_n is synchronous: clears charges, configuration and valid flags.
// A stalled result holds the input register; ready drops only when both are full.
module threshold_charge_neuron import tcn_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  tcn_in_if.sink         in_ch,
  tcn_out_if.source      out_ch,
  input  logic           cfg_we,
  input  cfg_idx_t       cfg_index,
  input  logic [CHG_W-1:0] cfg_wdata
);

  cfg_t      cfg_r;
  chg_t      cur_r;
  chg_t      pend_r;
  logic      s1_valid_r;
  func_t     s1_func_r;
  chg_t      s1_charge_r;
  logic      out_valid_r;
  core_res_t out_r;
  core_in_t  core_in;
  core_res_t core_res;
  logic      adv;
  logic      in_xfer;

  assign adv     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_xfer = in_ch.valid && in_ch.ready;

  assign core_in.func      = s1_func_r;
  assign core_in.charge_in = s1_charge_r;
  assign core_in.cur       = cur_r;
  assign core_in.pend      = pend_r;

  tcn_core u_core (
    .core_in (core_in),
    .cfg     (cfg_r),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRE_THRESHOLD:  cfg_r.thr        <= cfg_wdata;
        CFG_FIRE_FIXED_COST: cfg_r.fire_cost  <= cfg_wdata[AMT_W-1:0];
        CFG_FIRE_FRACTION:   cfg_r.fire_frac  <= cfg_wdata[FRAC_W-1:0];
        CFG_LEAK_FIXED:      cfg_r.leak_fixed <= cfg_wdata[AMT_W-1:0];
        CFG_LEAK_FRACTION:   cfg_r.leak_frac  <= cfg_wdata[FRAC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
      pend_r      <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        cur_r       <= core_res.cur;
        pend_r      <= core_res.pend;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r   <= in_ch.func;
      s1_charge_r <= in_ch.charge_in;
    end
    if (adv) begin
      out_r <= core_res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.signal_out      = out_r.signal;
  assign out_ch.above_threshold = out_r.above;
  assign out_ch.current_level   = out_r.cur;
  assign out_ch.pending_level   = out_r.pend;

endmodule

/* rtl/tcn_core.sv */
// Next-state and result logic for one event against the current charges.
module tcn_core import tcn_pkg::*; (
  input  core_in_t  core_in,
  input  cfg_t      cfg,
  output core_res_t res
);

  chg_t            lf;
  chg_t            fc;
  chg_t            x_dec;
  chg_t            x_trg;
  chg_t            base_sig;
  logic            dec_le;
  logic            trg_small;
  logic            fire;
  logic            is_dec;
  amt_t            x;
  frac_t           g;
  logic [PROD_W-1:0] prod;
  amt_t            share;
  amt_t            share_up;
  amt_t            scaled;

  // Both decay and trigger scale a non-negative remainder x by g and by 1-g;
  // they never happen together, so one multiplier serves both.
  always_comb begin
    lf        = {1'b0, cfg.leak_fixed};
    fc        = {1'b0, cfg.fire_cost};
    dec_le    = core_in.cur <= lf;
    trg_small = core_in.cur <= fc;
    fire      = core_in.cur >= cfg.thr;
    x_dec     = dec_le ? '0 : core_in.cur - lf;
    x_trg     = trg_small ? '0 : core_in.cur - fc;
    base_sig  = trg_small ? core_in.cur : fc;
    is_dec    = core_in.func == FUNC_DECAY;
    x         = is_dec ? x_dec[AMT_W-1:0] : x_trg[AMT_W-1:0];
    g         = is_dec ? frac_sat(cfg.leak_frac) : frac_sat(cfg.fire_frac);
    prod      = {{FRAC_W{1'b0}}, x} * {{AMT_W{1'b0}}, g};
    share     = prod[FRAC_BITS +: AMT_W];
    // floor(x*(1-g)) = x - ceil(x*g)
    share_up  = share + AMT_W'(|prod[FRAC_BITS-1:0]);
    scaled    = x - share_up;
  end

  always_comb begin
    res.signal = '0;
    res.cur    = core_in.cur;
    res.pend   = core_in.pend;
    unique case (core_in.func)
      FUNC_ADD: begin
        res.pend = sat_add(core_in.pend, core_in.charge_in);
      end
      FUNC_ASSIM: begin
        res.cur  = sat_add(core_in.cur, core_in.pend);
        res.pend = '0;
      end
      FUNC_INJECT: begin
        res.cur = sat_add(core_in.cur, core_in.charge_in);
      end
      FUNC_DECAY: begin
        res.cur = {1'b0, scaled};
      end
      FUNC_TRIGGER: begin
        if (fire) begin
          // share never exceeds the remainder, so this sum cannot overflow
          res.signal = base_sig + chg_t'({1'b0, share});
          res.cur    = {1'b0, scaled};
        end
      end
      FUNC_CLEAR: begin
        res.cur  = '0;
        res.pend = '0;
      end
      default: begin
      end
    endcase
    res.above = res.cur >= cfg.thr;
  end

endmodule

/* rtl/tcn_checker.sv */
// Port-level assertions for the threshold charge neuron, bound to the top level.
module tcn_checker import tcn_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input chg_t out_signal,
  input logic out_above,
  input chg_t out_cur,
  input chg_t out_pend
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_signal) && $stable(out_above)
      && $stable(out_cur) && $stable(out_pend))
    else $error("stalled result changed");

  // a fresh result must come from an input transfer, through the input and result registers
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching input transfer");

  // input backpressure only when the output side is stalled
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output free");

endmodule

bind threshold_charge_neuron tcn_checker u_tcn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_signal (out_ch.signal_out),
  .out_above  (out_ch.above_threshold),
  .out_cur    (out_ch.current_level),
  .out_pend   (out_ch.pending_level)
);
